/* rtl/core/clfsg_pkg.sv */
// package for the coil launcher fire window and speed gate block
// shared types and constants, no dependencies
package clfsg_pkg;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned DIST_W     = 20;
	localparam int unsigned WIN_W      = 16;
	localparam int unsigned RES_W      = 32;
	localparam int unsigned NUM_W      = 30;   // distance * 1000 fits in 30 bits
	localparam int unsigned STEP_CNT_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_FIRE_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GATE_A_DIST = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GATE_B_DIST = 2'd3;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV_A,
		BK_DIV_B,
		BK_OUT
	} back_state_t;

endpackage

/* rtl/core/clfsg_if.sv */
// valid/ready channel interfaces for the poll, result and config channels
// depends on clfsg_pkg
interface clfsg_poll_if;
	logic        valid;
	logic        ready;
	logic [31:0] now_ms;
	logic [31:0] now_us;
	logic        hall_trigger;
	logic        hall_gate_a_start;
	logic        hall_gate_a_end;
	logic        hall_gate_b_start;
	logic        hall_gate_b_end;
	modport source (output valid, now_ms, now_us, hall_trigger, hall_gate_a_start,
		hall_gate_a_end, hall_gate_b_start, hall_gate_b_end, input ready);
	modport sink (input valid, now_ms, now_us, hall_trigger, hall_gate_a_start,
		hall_gate_a_end, hall_gate_b_start, hall_gate_b_end, output ready);
endinterface

interface clfsg_result_if;
	logic        valid;
	logic        ready;
	logic        drive_coil_one;
	logic        drive_coil_two;
	logic        gate_a_valid;
	logic [31:0] gate_a_gap_us;
	logic [31:0] gate_a_speed_mm_s;
	logic        gate_b_valid;
	logic [31:0] gate_b_gap_us;
	logic [31:0] gate_b_speed_mm_s;
	modport source (output valid, drive_coil_one, drive_coil_two, gate_a_valid,
		gate_a_gap_us, gate_a_speed_mm_s, gate_b_valid, gate_b_gap_us,
		gate_b_speed_mm_s, input ready);
	modport sink (input valid, drive_coil_one, drive_coil_two, gate_a_valid,
		gate_a_gap_us, gate_a_speed_mm_s, gate_b_valid, gate_b_gap_us,
		gate_b_speed_mm_s, output ready);
endinterface

interface clfsg_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/clfsg_front.sv */
// front end: accepts polls, updates fire window and gate latches, forms a job
// depends on clfsg_pkg
module clfsg_front #(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [31:0]                      now_ms,
	input  logic [31:0]                      now_us,
	input  logic                             hall_trigger,
	input  logic                             hall_gate_a_start,
	input  logic                             hall_gate_a_end,
	input  logic                             hall_gate_b_start,
	input  logic                             hall_gate_b_end,
	input  logic [clfsg_pkg::WIN_W-1:0]      fire_window_ms,
	input  logic [clfsg_pkg::WIN_W-1:0]      cooldown_ms,
	input  logic [clfsg_pkg::DIST_W-1:0]     dist_a,
	input  logic [clfsg_pkg::DIST_W-1:0]     dist_b,
	output logic                             job_valid,
	input  logic                             job_ready,
	output logic                             job_coil1,
	output logic                             job_coil2,
	output logic                             job_a_hit,
	output logic [TIME_BITS-1:0]             job_a_gap,
	output logic [clfsg_pkg::DIST_W-1:0]     job_a_dist,
	output logic                             job_b_hit,
	output logic [TIME_BITS-1:0]             job_b_gap,
	output logic [clfsg_pkg::DIST_W-1:0]     job_b_dist
);
	localparam int unsigned EXT_W = (TIME_BITS > 32) ? TIME_BITS : 32;

	logic [TIME_BITS-1:0] fire_start_q, a_start_q, b_start_q;
	logic [TIME_BITS-1:0] ms_t, us_t, start_eff, elapsed, gap_a, gap_b;
	logic [EXT_W-1:0]     now_ms_x, now_us_x;
	logic                 in_win, cool_done, a_arm, b_arm, a_end_hit, b_end_hit;
	logic                 take;

	assign now_ms_x = EXT_W'(now_ms);
	assign now_us_x = EXT_W'(now_us);
	assign ms_t = now_ms_x[TIME_BITS-1:0];
	assign us_t = now_us_x[TIME_BITS-1:0];

	// one-deep job register is the queue slot toward the back end
	assign in_ready = !job_valid || job_ready;
	assign take     = in_valid && in_ready;

	assign start_eff = (!hall_trigger && fire_start_q == '0) ? ms_t : fire_start_q;
	assign elapsed   = ms_t - start_eff;
	assign in_win    = elapsed <= TIME_BITS'(fire_window_ms);
	assign cool_done = !in_win && (elapsed >= TIME_BITS'(cooldown_ms));

	assign a_arm     = hall_trigger && !hall_gate_a_start && a_start_q == '0 && hall_gate_a_end;
	assign b_arm     = hall_trigger && !hall_gate_b_start && b_start_q == '0 && hall_gate_b_end;
	assign a_end_hit = hall_trigger && !hall_gate_a_end && a_start_q != '0;
	assign b_end_hit = hall_trigger && !hall_gate_b_end && b_start_q != '0;
	assign gap_a     = us_t - a_start_q;
	assign gap_b     = us_t - b_start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fire_start_q <= '0;
			a_start_q    <= '0;
			b_start_q    <= '0;
			job_valid    <= 1'b0;
		end else begin
			if (take) begin
				fire_start_q <= cool_done ? '0 : start_eff;
				if (a_arm) a_start_q <= us_t;
				else if (a_end_hit) a_start_q <= '0;
				if (b_arm) b_start_q <= us_t;
				else if (b_end_hit) b_start_q <= '0;
				job_valid <= 1'b1;
			end else if (job_ready) begin
				job_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_coil1  <= in_win && !hall_trigger;
			job_coil2  <= in_win && hall_trigger && !hall_gate_a_end;
			job_a_hit  <= a_end_hit && gap_a > TIME_BITS'(1);
			job_a_gap  <= gap_a;
			job_a_dist <= dist_a;
			job_b_hit  <= b_end_hit && gap_b > TIME_BITS'(1);
			job_b_gap  <= gap_b;
			job_b_dist <= dist_b;
		end
	end
endmodule

/* rtl/core/clfsg_div.sv */
// restoring divider, one quotient bit per cycle, 30-bit quotient zero-extended to 32 bits
// depends on clfsg_pkg
module clfsg_div #(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [clfsg_pkg::NUM_W-1:0]  numer,
	input  logic [TIME_BITS-1:0]         denom,
	output logic                         done,
	output logic [clfsg_pkg::RES_W-1:0]  quot
);
	localparam int unsigned NW = clfsg_pkg::NUM_W;
	localparam int unsigned RW = TIME_BITS + 1;

	logic [NW-1:0]                   q_q;
	logic [RW-1:0]                   rem_q, trial;
	logic [TIME_BITS-1:0]            den_q;
	logic [clfsg_pkg::STEP_CNT_W-1:0] cnt_q;
	logic                            busy_q;

	assign trial = {rem_q[RW-2:0], q_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= clfsg_pkg::STEP_CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - clfsg_pkg::STEP_CNT_W'(1);
				if (cnt_q == clfsg_pkg::STEP_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				q_q   <= {q_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q   <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	// quotient of a 30-bit numerator never exceeds 32 bits
	assign quot = clfsg_pkg::RES_W'(q_q);

	div_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy_q)) else $error("divider done without work");
	div_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider restarted while busy");
	div_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < {1'b0, den_q}) else $error("divider remainder out of range");
endmodule

/* rtl/core/clfsg_back.sv */
// back end: up to two speed divisions on the shared divider, then the result register
// depends on clfsg_pkg and clfsg_div
module clfsg_back #(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         job_valid,
	output logic                         job_ready,
	input  logic                         job_coil1,
	input  logic                         job_coil2,
	input  logic                         job_a_hit,
	input  logic [TIME_BITS-1:0]         job_a_gap,
	input  logic [clfsg_pkg::DIST_W-1:0] job_a_dist,
	input  logic                         job_b_hit,
	input  logic [TIME_BITS-1:0]         job_b_gap,
	input  logic [clfsg_pkg::DIST_W-1:0] job_b_dist,
	clfsg_result_if.source               res
);
	clfsg_pkg::back_state_t state_q, state_d;
	logic                        div_start, div_done;
	logic [clfsg_pkg::NUM_W-1:0] numer;
	logic [TIME_BITS-1:0]        denom;
	logic [clfsg_pkg::RES_W-1:0] quot;
	logic                        c1_q, c2_q, ah_q, bh_q, started_q;
	logic [TIME_BITS-1:0]        ag_q, bg_q;
	logic [clfsg_pkg::DIST_W-1:0] ad_q, bd_q;
	logic [clfsg_pkg::RES_W-1:0] as_q;

	// take a job only when idle
	assign job_ready = (state_q == clfsg_pkg::BK_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			clfsg_pkg::BK_IDLE: if (job_valid) state_d = clfsg_pkg::BK_DIV_A;
			clfsg_pkg::BK_DIV_A: if (!ah_q || div_done) state_d = clfsg_pkg::BK_DIV_B;
			clfsg_pkg::BK_DIV_B: if (!bh_q || div_done) state_d = clfsg_pkg::BK_OUT;
			clfsg_pkg::BK_OUT: if (res.ready) state_d = clfsg_pkg::BK_IDLE;
			default: state_d = clfsg_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		numer     = '0;
		denom     = '0;
		unique case (state_q)
			clfsg_pkg::BK_DIV_A: begin
				div_start = ah_q && !started_q;
				numer     = clfsg_pkg::NUM_W'(ad_q) * clfsg_pkg::NUM_W'(1000);
				denom     = ag_q;
			end
			clfsg_pkg::BK_DIV_B: begin
				div_start = bh_q && !started_q;
				numer     = clfsg_pkg::NUM_W'(bd_q) * clfsg_pkg::NUM_W'(1000);
				denom     = bg_q;
			end
			default: ;
		endcase
	end

	clfsg_div #(.TIME_BITS(TIME_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .numer(numer), .denom(denom),
		.done(div_done), .quot(quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= clfsg_pkg::BK_IDLE;
			started_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d) started_q <= 1'b0;
			else if (div_start) started_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == clfsg_pkg::BK_IDLE && job_valid) begin
			c1_q <= job_coil1; c2_q <= job_coil2;
			ah_q <= job_a_hit; ag_q <= job_a_gap; ad_q <= job_a_dist;
			bh_q <= job_b_hit; bg_q <= job_b_gap; bd_q <= job_b_dist;
		end
		if (state_q == clfsg_pkg::BK_DIV_A && div_done) as_q <= quot;
		if (state_q == clfsg_pkg::BK_DIV_B) begin
			res.drive_coil_one    <= c1_q;
			res.drive_coil_two    <= c2_q;
			res.gate_a_valid      <= ah_q;
			res.gate_a_gap_us     <= ah_q ? clfsg_pkg::RES_W'(ag_q) : '0;
			res.gate_a_speed_mm_s <= ah_q ? as_q : '0;
			res.gate_b_valid      <= bh_q;
			res.gate_b_gap_us     <= bh_q ? clfsg_pkg::RES_W'(bg_q) : '0;
			res.gate_b_speed_mm_s <= bh_q ? quot : '0;
		end
	end

	assign res.valid = (state_q == clfsg_pkg::BK_OUT);

	bk_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> res.valid) else $error("result dropped");
	bk_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		job_ready |-> !res.valid) else $error("job taken with result pending");
	bk_coils_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.drive_coil_one && res.drive_coil_two))
		else $error("both coils driven");
endmodule

/* rtl/core/coil_launch_fire_and_speed_gate.sv */
// top level of the coil launcher fire window and speed gate block
// depends on clfsg_pkg, clfsg_if, clfsg_front, clfsg_back
//
// Each poll transaction carries ms and us stamps and five active-low hall levels
// and yields exactly one result transaction. The front end updates the fire window
// and the two gate latches in the cycle a poll is taken and hands a job to the
// back end through a one-deep job register; the back end runs up to two speed
// divisions (distance_um*1000/gap) on one shared restoring divider, one quotient
// bit per cycle while a division runs; the result is held until ready. The
// front end takes the next poll while the back end is still busy with one job.
// Configuration writes are always accepted and should be made while idle.
module coil_launch_fire_and_speed_gate #(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	clfsg_poll_if.sink    poll,
	clfsg_result_if.source result,
	clfsg_cfg_if.sink     cfg
);
	logic [clfsg_pkg::WIN_W-1:0]  fire_window_q, cooldown_q;
	logic [clfsg_pkg::DIST_W-1:0] dist_a_q, dist_b_q;

	// job between front and back end
	logic                         job_valid, job_ready, job_coil1, job_coil2;
	logic                         job_a_hit, job_b_hit;
	logic [TIME_BITS-1:0]         job_a_gap, job_b_gap;
	logic [clfsg_pkg::DIST_W-1:0] job_a_dist, job_b_dist;

	// configuration register file
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fire_window_q <= 16'd2000;
			cooldown_q    <= 16'd10000;
			dist_a_q      <= 20'd20000;
			dist_b_q      <= 20'd20000;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				clfsg_pkg::REG_FIRE_WINDOW: fire_window_q <= cfg.data[15:0];
				clfsg_pkg::REG_COOLDOWN:    cooldown_q    <= cfg.data[15:0];
				clfsg_pkg::REG_GATE_A_DIST: dist_a_q      <= cfg.data[19:0];
				clfsg_pkg::REG_GATE_B_DIST: dist_b_q      <= cfg.data[19:0];
				default: ;
			endcase
		end
	end

	clfsg_front #(.TIME_BITS(TIME_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(poll.valid), .in_ready(poll.ready),
		.now_ms(poll.now_ms), .now_us(poll.now_us),
		.hall_trigger(poll.hall_trigger),
		.hall_gate_a_start(poll.hall_gate_a_start), .hall_gate_a_end(poll.hall_gate_a_end),
		.hall_gate_b_start(poll.hall_gate_b_start), .hall_gate_b_end(poll.hall_gate_b_end),
		.fire_window_ms(fire_window_q), .cooldown_ms(cooldown_q),
		.dist_a(dist_a_q), .dist_b(dist_b_q),
		.job_valid(job_valid), .job_ready(job_ready),
		.job_coil1(job_coil1), .job_coil2(job_coil2),
		.job_a_hit(job_a_hit), .job_a_gap(job_a_gap), .job_a_dist(job_a_dist),
		.job_b_hit(job_b_hit), .job_b_gap(job_b_gap), .job_b_dist(job_b_dist)
	);

	clfsg_back #(.TIME_BITS(TIME_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(job_valid), .job_ready(job_ready),
		.job_coil1(job_coil1), .job_coil2(job_coil2),
		.job_a_hit(job_a_hit), .job_a_gap(job_a_gap), .job_a_dist(job_a_dist),
		.job_b_hit(job_b_hit), .job_b_gap(job_b_gap), .job_b_dist(job_b_dist),
		.res(result)
	);

	top_job_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid && !job_ready) |=> job_valid) else $error("job lost");
	top_poll_block: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid && !job_ready) |-> !poll.ready) else $error("poll taken over job");
	top_gate_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.gate_a_valid) |-> result.gate_a_gap_us > 32'd1)
		else $error("gate a gap too small");
endmodule
